### rtl/core/dr_pkg.sv
package dr_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int TAYLOR_TERMS = 7;
    localparam int Q30_W        = 32;
    localparam int SC_STAGES    = 3 + 3 * TAYLOR_TERMS;
    localparam int MIX_STAGES   = 6;
    localparam int LATENCY      = SC_STAGES + MIX_STAGES;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;

    typedef struct packed {
        logic [15:0] track_polar;
        logic [15:0] track_azimuth;
        logic [15:0] deflect_polar;
        logic [15:0] deflect_azimuth;
    } t_dr_in;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_dr_out;

    function automatic logic signed [Q30_W-1:0] qround(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = p[63] ? 64'(-p) : 64'(p);
        rnd = (mag + (64'd1 << 29)) >> 30;
        return p[63] ? -$signed(Q30_W'(rnd)) : $signed(Q30_W'(rnd));
    endfunction

endpackage

### rtl/core/direction_rotation.sv
// Throughput: one transfer per cycle; a stalled output holds the whole pipeline.
// Sine and cosine units feed the matrix product, rounding and saturation stages.
// Reset (synchronous, active low) clears the valid bits only; data registers
// are not reset.
module direction_rotation (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dr_pkg::t_dr_in i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dr_pkg::t_dr_out o_data
);
    import dr_pkg::*;

    localparam int SH    = 60 - FRAC_BITS;
    localparam int MAG_W = FRAC_BITS + 3;

    logic r_vld [0:LATENCY-1];
    logic w_en;

    logic signed [Q30_W-1:0] w_sth, w_cth, w_sph, w_cph, w_sdp, w_cdp, w_sda, w_cda;

    logic signed [63:0]      r_pv0, r_pv1, r_pm01, r_pm11, r_pm02, r_pm12;
    logic signed [Q30_W-1:0] r_sph1, r_cph1, r_sth1, r_cth1, r_cdp1;
    logic signed [Q30_W-1:0] r_v0, r_v1, r_m01, r_m11, r_m02, r_m12;
    logic signed [Q30_W-1:0] r_nsph2, r_cph2, r_sth2, r_cth2, r_cdp2;
    logic signed [63:0]      r_px0, r_px1, r_px2, r_py0, r_py1, r_py2, r_pz0, r_pz1;
    logic signed [63:0]      r_ax, r_ay, r_az;
    logic                    r_nx, r_ny, r_nz;
    logic [MAG_W-1:0]        r_mx, r_my, r_mz;
    t_dr_out                 r_out;

    function automatic logic [MAG_W-1:0] mag_round(input logic signed [63:0] acc);
        logic [63:0] mag;
        mag = acc[63] ? 64'(-acc) : 64'(acc);
        return MAG_W'((mag + (64'd1 << (SH - 1))) >> SH);
    endfunction

    function automatic logic signed [15:0] sat_sign(input logic neg, input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0] v;
        v = (m > (MAG_W'(1) << FRAC_BITS)) ? (MAG_W'(1) << FRAC_BITS) : m;
        return neg ? -$signed(16'(v)) : $signed(16'(v));
    endfunction

    assign w_en    = !r_vld[LATENCY-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LATENCY-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LATENCY; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < LATENCY; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    dr_sincos u_track_polar (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (ANGLE_BITS'(i_data.track_polar)),
        .o_sin   (w_sth),
        .o_cos   (w_cth)
    );

    dr_sincos u_track_azimuth (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (ANGLE_BITS'(i_data.track_azimuth)),
        .o_sin   (w_sph),
        .o_cos   (w_cph)
    );

    dr_sincos u_deflect_polar (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (ANGLE_BITS'(i_data.deflect_polar)),
        .o_sin   (w_sdp),
        .o_cos   (w_cdp)
    );

    dr_sincos u_deflect_azimuth (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (ANGLE_BITS'(i_data.deflect_azimuth)),
        .o_sin   (w_sda),
        .o_cos   (w_cda)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pv0  <= w_sdp * w_cda;
            r_pv1  <= w_sdp * w_sda;
            r_pm01 <= w_cph * w_cth;
            r_pm11 <= w_sph * w_cth;
            r_pm02 <= w_sth * w_cph;
            r_pm12 <= w_sth * w_sph;
            r_sph1 <= w_sph;
            r_cph1 <= w_cph;
            r_sth1 <= w_sth;
            r_cth1 <= w_cth;
            r_cdp1 <= w_cdp;

            r_v0    <= qround(r_pv0);
            r_v1    <= qround(r_pv1);
            r_m01   <= -qround(r_pm01);
            r_m11   <= -qround(r_pm11);
            r_m02   <= qround(r_pm02);
            r_m12   <= qround(r_pm12);
            r_nsph2 <= -r_sph1;
            r_cph2  <= r_cph1;
            r_sth2  <= r_sth1;
            r_cth2  <= r_cth1;
            r_cdp2  <= r_cdp1;

            r_px0 <= r_nsph2 * r_v0;
            r_px1 <= r_m01 * r_v1;
            r_px2 <= r_m02 * r_cdp2;
            r_py0 <= r_cph2 * r_v0;
            r_py1 <= r_m11 * r_v1;
            r_py2 <= r_m12 * r_cdp2;
            r_pz0 <= r_sth2 * r_v1;
            r_pz1 <= r_cth2 * r_cdp2;

            r_ax <= r_px0 + r_px1 + r_px2;
            r_ay <= r_py0 + r_py1 + r_py2;
            r_az <= r_pz0 + r_pz1;

            r_nx <= r_ax[63];
            r_ny <= r_ay[63];
            r_nz <= r_az[63];
            r_mx <= mag_round(r_ax);
            r_my <= mag_round(r_ay);
            r_mz <= mag_round(r_az);

            r_out.dir_x <= sat_sign(r_nx, r_mx);
            r_out.dir_y <= sat_sign(r_ny, r_my);
            r_out.dir_z <= sat_sign(r_nz, r_mz);
        end
    end

endmodule

### rtl/core/dr_sincos.sv
module dr_sincos (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [dr_pkg::ANGLE_BITS-1:0]     i_angle,
    output logic signed [dr_pkg::Q30_W-1:0]   o_sin,
    output logic signed [dr_pkg::Q30_W-1:0]   o_cos
);
    import dr_pkg::*;

    localparam int R_W  = ANGLE_BITS - 2;
    localparam int XP_W = R_W + 31;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [XP_W-1:0] w_xp;
    logic [1:0]      r_q1;
    logic [31:0]     r_x1;

    logic [31:0]        b_x2 [0:TAYLOR_TERMS];
    logic [31:0]        b_ts [0:TAYLOR_TERMS];
    logic [31:0]        b_tc [0:TAYLOR_TERMS];
    logic signed [33:0] b_s  [0:TAYLOR_TERMS];
    logic signed [33:0] b_c  [0:TAYLOR_TERMS];
    logic [1:0]         b_q  [0:TAYLOR_TERMS];

    logic signed [Q30_W-1:0] w_s;
    logic signed [Q30_W-1:0] w_c;

    assign w_xp = XP_W'(i_angle[R_W-1:0]) * XP_W'(HALF_PI_Q30)
                + (XP_W'(1) << (ANGLE_BITS - 3));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1 <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            r_x1 <= 32'(w_xp >> R_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            b_x2[0] <= 32'((64'(r_x1) * 64'(r_x1)) >> 30);
            b_ts[0] <= r_x1;
            b_tc[0] <= ONE_Q30;
            b_s[0]  <= $signed(34'(r_x1));
            b_c[0]  <= $signed(34'(ONE_Q30));
            b_q[0]  <= r_q1;
        end
    end

    for (genvar gi = 1; gi <= TAYLOR_TERMS; gi++) begin : g_term
        localparam int unsigned DS = (2 * gi) * (2 * gi + 1);
        localparam int unsigned DC = (2 * gi - 1) * (2 * gi);
        localparam int KS = 30 + $clog2(DS + 1);
        localparam int KC = 30 + $clog2(DC + 1);
        localparam logic [31:0] MS = 32'((64'd1 << KS) / DS);
        localparam logic [31:0] MC = 32'((64'd1 << KC) / DC);
        localparam bit SUB = (gi % 2) == 1;

        logic [63:0]        r_ps, r_pc, r_ms, r_mc;
        logic [31:0]        r_vs, r_vc;
        logic [31:0]        r_x2a, r_x2b;
        logic [1:0]         r_qa, r_qb;
        logic signed [33:0] r_sa, r_ca, r_sb, r_cb;
        logic [31:0]        w_qs, w_qc, w_rs, w_rc, w_ts, w_tc;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ps  <= 64'(b_ts[gi-1]) * 64'(b_x2[gi-1]);
                r_pc  <= 64'(b_tc[gi-1]) * 64'(b_x2[gi-1]);
                r_x2a <= b_x2[gi-1];
                r_qa  <= b_q[gi-1];
                r_sa  <= b_s[gi-1];
                r_ca  <= b_c[gi-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vs  <= r_ps[61:30];
                r_vc  <= r_pc[61:30];
                r_ms  <= 64'(r_ps[61:30]) * 64'(MS);
                r_mc  <= 64'(r_pc[61:30]) * 64'(MC);
                r_x2b <= r_x2a;
                r_qb  <= r_qa;
                r_sb  <= r_sa;
                r_cb  <= r_ca;
            end
        end

        assign w_qs = 32'(r_ms >> KS);
        assign w_qc = 32'(r_mc >> KC);
        assign w_rs = r_vs - 32'(w_qs * 32'(DS));
        assign w_rc = r_vc - 32'(w_qc * 32'(DC));
        assign w_ts = (w_rs >= 32'(DS)) ? w_qs + 32'd1 : w_qs;
        assign w_tc = (w_rc >= 32'(DC)) ? w_qc + 32'd1 : w_qc;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                b_ts[gi] <= w_ts;
                b_tc[gi] <= w_tc;
                b_x2[gi] <= r_x2b;
                b_q[gi]  <= r_qb;
                b_s[gi]  <= SUB ? r_sb - $signed(34'(w_ts)) : r_sb + $signed(34'(w_ts));
                b_c[gi]  <= SUB ? r_cb - $signed(34'(w_tc)) : r_cb + $signed(34'(w_tc));
            end
        end
    end

    always_comb begin
        if (b_s[TAYLOR_TERMS] < 0) begin
            w_s = '0;
        end else if (b_s[TAYLOR_TERMS] > $signed(34'(ONE_Q30))) begin
            w_s = $signed(ONE_Q30);
        end else begin
            w_s = Q30_W'(b_s[TAYLOR_TERMS]);
        end
        if (b_c[TAYLOR_TERMS] < 0) begin
            w_c = '0;
        end else if (b_c[TAYLOR_TERMS] > $signed(34'(ONE_Q30))) begin
            w_c = $signed(ONE_Q30);
        end else begin
            w_c = Q30_W'(b_c[TAYLOR_TERMS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (b_q[TAYLOR_TERMS])
                QUAD_0: begin
                    o_sin <= w_s;
                    o_cos <= w_c;
                end
                QUAD_1: begin
                    o_sin <= w_c;
                    o_cos <= -w_s;
                end
                QUAD_2: begin
                    o_sin <= -w_s;
                    o_cos <= -w_c;
                end
                QUAD_3: begin
                    o_sin <= -w_c;
                    o_cos <= w_s;
                end
                default: begin
                    o_sin <= w_s;
                    o_cos <= w_c;
                end
            endcase
        end
    end

endmodule

### sim/dr_checker.sv
module dr_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  dr_pkg::t_dr_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  dr_pkg::t_dr_out i_out_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    import dr_pkg::*;

    t_dr_out dir_fifo[$];

    // angle in, Q30 sine and cosine out
    function automatic void angle_sincos(input logic [15:0] ang,
                                         output longint s_o, output longint c_o);
        logic [1:0] quad;
        longint unsigned r, x, x2, ts, tc;
        longint s, c;
        quad = ang[15:14];
        r = ang[13:0];
        x = (r * 64'd1686629713 + 64'd8192) >> 14;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1073741824;
        s = x;
        c = 64'sd1073741824;
        for (int n = 1; n <= 7; n++) begin
            ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                s -= longint'(ts);
                c -= longint'(tc);
            end else begin
                s += longint'(ts);
                c += longint'(tc);
            end
        end
        if (s < 0) s = 0;
        if (s > 64'sd1073741824) s = 64'sd1073741824;
        if (c < 0) c = 0;
        if (c > 64'sd1073741824) c = 64'sd1073741824;
        case (quad)
            2'd0: begin s_o = s;  c_o = c;  end
            2'd1: begin s_o = c;  c_o = -s; end
            2'd2: begin s_o = -s; c_o = -c; end
            default: begin s_o = -c; c_o = s; end
        endcase
    endfunction

    function automatic longint round_away(input longint v, input int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [15:0] to_component(input longint acc);
        longint v;
        v = round_away(acc, 60 - FRAC_BITS);
        if (v > (64'sd1 <<< FRAC_BITS)) v = 64'sd1 <<< FRAC_BITS;
        if (v < -(64'sd1 <<< FRAC_BITS)) v = -(64'sd1 <<< FRAC_BITS);
        return v[15:0];
    endfunction

    function automatic t_dr_out rotate_direction(input t_dr_in d);
        longint sth, cth, sph, cph, sdp, cdp, sda, cda;
        longint v0, v1, v2, m01, m11, m02, m12;
        t_dr_out r;
        angle_sincos(d.track_polar, sth, cth);
        angle_sincos(d.track_azimuth, sph, cph);
        angle_sincos(d.deflect_polar, sdp, cdp);
        angle_sincos(d.deflect_azimuth, sda, cda);
        v0 = round_away(sdp * cda, 30);
        v1 = round_away(sdp * sda, 30);
        v2 = cdp;
        m01 = -round_away(cph * cth, 30);
        m11 = -round_away(sph * cth, 30);
        m02 = round_away(sth * cph, 30);
        m12 = round_away(sth * sph, 30);
        r.dir_x = to_component(-sph * v0 + m01 * v1 + m02 * v2);
        r.dir_y = to_component(cph * v0 + m11 * v1 + m12 * v2);
        r.dir_z = to_component(sth * v1 + cth * v2);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end

    assign o_pending = dir_fifo.size();

    always @(posedge i_clk) begin
        t_dr_out want;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            dir_fifo.push_back(rotate_direction(i_in_data));
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (dir_fifo.size() == 0) begin
                report_mismatch("unexpected transfer", 0, 0);
            end else begin
                want = dir_fifo.pop_front();
                o_checked++;
                if (i_out_data.dir_x !== want.dir_x)
                    report_mismatch("dir_x", i_out_data.dir_x, want.dir_x);
                if (i_out_data.dir_y !== want.dir_y)
                    report_mismatch("dir_y", i_out_data.dir_y, want.dir_y);
                if (i_out_data.dir_z !== want.dir_z)
                    report_mismatch("dir_z", i_out_data.dir_z, want.dir_z);
            end
        end
    end
endmodule

### sim/tb_top.sv
module tb_top;
    import dr_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_TAIL   = 300;
    localparam int WATCH_LIMIT  = 2000;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    t_dr_in  in_data;
    logic    out_valid;
    logic    out_ready;
    t_dr_out out_data;
    int      fail_count;
    int      pending;
    int      checked;
    int      stall_cycles;
    bit      quiet;
    int      idle_cycles;
    int      sent;

    direction_rotation u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    dr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hold valid and payload until the transfer
    task automatic send_item(input t_dr_in d);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_data  <= d;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] edges[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                  16'hC000, 16'h3FFF, 16'h7FFF, 16'h0001};
        if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    // receiver stalls in bursts
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cycles = $urandom_range(0, 12);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dr_in d;
        static logic [15:0] corners[6] = '{16'h0000, 16'hFFFF, 16'h4000,
                                           16'h8000, 16'hC000, 16'h2000};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        stall_cycles = 0;
        quiet        = 1'b0;
        idle_cycles  = 0;
        sent         = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < 24; k++) begin
            d.track_polar     = corners[k % 6];
            d.track_azimuth   = corners[(k / 6 + k) % 6];
            d.deflect_polar   = corners[(k * 5) % 6];
            d.deflect_azimuth = corners[(k / 4) % 6];
            send_item(d);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (k == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
            d.track_polar     = pick_angle();
            d.track_azimuth   = pick_angle();
            d.deflect_polar   = pick_angle();
            d.deflect_azimuth = pick_angle();
            send_item(d);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d direction pairs, checked %0d rotated directions,", sent, checked);
        $display("with corner angles, random angles and stalls on both channels.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/dr_pkg.sv
rtl/core/dr_sincos.sv
rtl/core/direction_rotation.sv
sim/dr_checker.sv
sim/tb_top.sv
